// ===== hw/rtl/egbw_pkg.sv =====
// Shared types and constants of the Exp-Golomb bit writer.
`default_nettype none

package egbw_pkg;

    // Most result items that one request can produce.
    localparam int MAX_RESULTS = 8;

    // Bit accumulator: up to 7 pending bits plus a 32-bit field.
    localparam int ACC_W = 39;
    localparam int CNT_W = 6;

    // Width of byte positions and counts.
    localparam int IDX_W = 31;

    // Work list for one request, as handed from the front to the back.
    typedef struct packed {
        logic        restart;  // clear pending bits, byte count and overflow
        logic        pad;      // zero fill to the next byte boundary at the end
        logic [4:0]  n_a;      // length of the zero prefix
        logic [5:0]  n_b;      // length of the main field
        logic [31:0] val_b;    // main field, right-aligned and masked
    } t_desc;

    // One result entry before the per-request summary is attached.
    typedef struct packed {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic [IDX_W-1:0] byte_index;
    } t_res_entry;

    // Values shared by all results of one request.
    typedef struct packed {
        logic [IDX_W-1:0] byte_count;
        logic             overflow;
        logic [3:0]       n_res;
    } t_summary;

endpackage

`default_nettype wire

// ===== hw/rtl/egbw_front.sv =====
// Front end: accepts requests and turns each into a work list for the back end.
`default_nettype none

module egbw_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire logic [2:0]          i_req_type,
    input  wire logic [31:0]         i_value,
    input  wire logic [5:0]          i_bit_count,
    input  wire logic                i_desc_full,
    output logic                     o_desc_we,
    output egbw_pkg::t_desc          o_desc
);

    localparam logic [2:0] REQ_PUT_BITS = 3'd0;
    localparam logic [2:0] REQ_UE       = 3'd1;
    localparam logic [2:0] REQ_SE       = 3'd2;
    localparam logic [2:0] REQ_TRAILING = 3'd3;
    localparam logic [2:0] REQ_ALIGN    = 3'd4;
    localparam logic [2:0] REQ_START    = 3'd5;
    localparam logic [2:0] REQ_RESTART  = 3'd6;

    // Number of significant bits of a word.
    function automatic logic [5:0] bit_length(input logic [31:0] w);
        logic [5:0] len;
        len = 6'd0;
        for (int i = 0; i < 32; i++) begin
            if (w[i]) begin
                len = 6'(i + 1);
            end
        end
        return len;
    endfunction

    logic        r_s1_valid;
    logic [2:0]  r_s1_req;
    logic [31:0] r_s1_word;
    logic [5:0]  r_s1_n;

    logic        accept;
    logic        advance;
    logic [5:0]  n_clamp;
    logic [31:0] field_mask;
    logic [31:0] neg_value;
    logic [31:0] in_word;
    logic [5:0]  code_len;

    assign advance = r_s1_valid && !i_desc_full;
    assign o_full  = r_s1_valid && i_desc_full;
    assign accept  = i_push && !o_full;

    // Input side: clamp and mask raw fields, form code words (value plus one).
    assign n_clamp    = (i_bit_count > 6'd32) ? 6'd32 : i_bit_count;
    assign field_mask = (n_clamp == 6'd32) ? 32'hFFFF_FFFF
                                           : ((32'd1 << n_clamp[4:0]) - 32'd1);
    assign neg_value  = 32'd0 - i_value;

    always_comb begin
        case (i_req_type)
            REQ_PUT_BITS: in_word = i_value & field_mask;
            REQ_UE:       in_word = i_value + 32'd1;
            REQ_SE: begin
                // Zero and negative values map to odd codes, positive to even.
                if (i_value[31] || (i_value == 32'd0)) begin
                    in_word = {neg_value[30:0], 1'b1};
                end else begin
                    in_word = {i_value[30:0], 1'b0};
                end
            end
            default:      in_word = i_value;
        endcase
    end

    // Request stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req  <= i_req_type;
            r_s1_word <= in_word;
            r_s1_n    <= n_clamp;
        end
    end

    // Classify the staged request into a prefix, a field and a pad step.
    assign code_len  = bit_length(r_s1_word);
    assign o_desc_we = advance;

    always_comb begin
        o_desc = '0;
        unique case (r_s1_req) inside
            REQ_PUT_BITS: begin
                o_desc.n_b   = r_s1_n;
                o_desc.val_b = r_s1_word;
            end
            REQ_UE, REQ_SE: begin
                if (code_len != 6'd0) begin
                    o_desc.n_a   = 5'(code_len - 6'd1);
                    o_desc.n_b   = code_len;
                    o_desc.val_b = r_s1_word;
                end
            end
            REQ_TRAILING: begin
                o_desc.n_b   = 6'd1;
                o_desc.val_b = 32'd1;
                o_desc.pad   = 1'b1;
            end
            REQ_ALIGN: begin
                o_desc.pad = 1'b1;
            end
            REQ_START: begin
                o_desc.n_b   = 6'd32;
                o_desc.val_b = 32'd1;
            end
            REQ_RESTART: begin
                o_desc.restart = 1'b1;
            end
            default: begin
                o_desc = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/egbw_desc_fifo.sv =====
// Short queue of work lists between the front end and the back end.
`default_nettype none

module egbw_desc_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire egbw_pkg::t_desc  i_desc,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output egbw_pkg::t_desc       o_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    egbw_pkg::t_desc  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_we) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_we && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_we) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/egbw_back.sv =====
// Back end: bit accumulator that loads fields and emits whole bytes, one step a cycle.
`default_nettype none

module egbw_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [egbw_pkg::IDX_W-1:0]  i_cfg_data,
    input  wire egbw_pkg::t_desc             i_desc,
    input  wire logic                        i_desc_valid,
    output logic                             o_desc_pop,
    input  wire logic                        i_room,
    output logic                             o_res_we,
    output egbw_pkg::t_res_entry             o_res,
    output logic                             o_sum_we,
    output egbw_pkg::t_summary               o_sum
);

    localparam int ACC_W = egbw_pkg::ACC_W;
    localparam int CNT_W = egbw_pkg::CNT_W;
    localparam int IDX_W = egbw_pkg::IDX_W;

    logic [IDX_W-1:0] r_cap;
    logic             r_active;
    logic             r_a_pend;
    logic             r_b_pend;
    logic             r_pad_pend;
    logic [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [2:0]       r_keep;
    logic [IDX_W-1:0] r_bw;
    logic             r_ovf;
    logic [3:0]       r_nbytes;

    logic             n_active;
    logic             n_a_pend;
    logic             n_b_pend;
    logic             n_pad_pend;
    logic [ACC_W-1:0] n_acc;
    logic [CNT_W-1:0] n_cnt;
    logic [2:0]       n_keep;
    logic [IDX_W-1:0] n_bw;
    logic             n_ovf;
    logic [3:0]       n_nbytes;

    logic             go;
    logic             cur_a;
    logic             cur_b;
    logic             cur_pad;
    logic [3:0]       cur_nbytes;
    logic             ld_en;
    logic [31:0]      ld_val;
    logic [CNT_W-1:0] ld_n;
    logic [6:0]       pend;
    logic [ACC_W-1:0] ld_acc;
    logic [CNT_W-1:0] ld_total;
    logic [2:0]       ld_keep;
    logic [ACC_W-1:0] shifted;
    logic [7:0]       emit_byte;
    logic             done;

    assign o_cfg_ready = 1'b1;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // Work still open for the current request; a new request starts from its list.
    assign go         = r_active || (i_desc_valid && i_room);
    assign cur_a      = r_active ? r_a_pend   : (i_desc.n_a != 5'd0);
    assign cur_b      = r_active ? r_b_pend   : (i_desc.n_b != 6'd0);
    assign cur_pad    = r_active ? r_pad_pend : i_desc.pad;
    assign cur_nbytes = r_active ? r_nbytes   : 4'd0;

    // Field load: pending bits shifted up, new field below them.
    assign pend     = r_acc[6:0] & ((7'd1 << r_cnt[2:0]) - 7'd1);
    assign ld_acc   = ({32'd0, pend} << ld_n) | {7'd0, ld_val};
    assign ld_total = r_cnt + ld_n;
    assign ld_keep  = (ld_total > 6'd32) ? 3'(ld_total - 6'd32) : 3'd0;

    // Oldest whole byte of the accumulator.
    assign shifted   = r_acc >> (r_cnt - 6'd8);
    assign emit_byte = shifted[7:0];

    // Pick the next load step.
    always_comb begin
        ld_en  = 1'b0;
        ld_val = 32'd0;
        ld_n   = '0;
        if (go && !(!r_active && i_desc.restart) && (r_cnt < 6'd8)) begin
            if (cur_a) begin
                ld_en = 1'b1;
                ld_n  = {1'b0, i_desc.n_a};
            end else if (cur_b) begin
                ld_en  = 1'b1;
                ld_val = i_desc.val_b;
                ld_n   = i_desc.n_b;
            end else if (cur_pad && (r_cnt != '0)) begin
                ld_en = 1'b1;
                ld_n  = 6'd8 - r_cnt;
            end
        end
    end

    // One step: restart, emit a byte, drop the rest of a chunk on overflow, or load a field.
    always_comb begin
        n_active   = r_active;
        n_a_pend   = cur_a;
        n_b_pend   = cur_b;
        n_pad_pend = cur_pad;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_keep     = r_keep;
        n_bw       = r_bw;
        n_ovf      = r_ovf;
        n_nbytes   = cur_nbytes;
        o_res_we   = 1'b0;
        o_res      = '0;
        o_sum_we   = 1'b0;
        o_sum      = '0;
        o_desc_pop = 1'b0;
        done       = 1'b0;

        if (go) begin
            if (!r_active && i_desc.restart) begin
                n_cnt = '0;
                n_bw  = '0;
                n_ovf = 1'b0;
            end else if (r_cnt >= 6'd8) begin
                if (r_bw >= r_cap) begin
                    // Buffer full: drop what is left of this chunk.
                    n_ovf = 1'b1;
                    n_cnt = {3'd0, r_keep};
                end else begin
                    o_res_we         = 1'b1;
                    o_res.has_byte   = 1'b1;
                    o_res.out_byte   = emit_byte;
                    o_res.byte_index = r_bw;
                    n_bw             = r_bw + 1'b1;
                    n_cnt            = r_cnt - 6'd8;
                    n_nbytes         = cur_nbytes + 4'd1;
                end
            end else if (ld_en) begin
                n_acc  = ld_acc;
                n_cnt  = ld_total;
                n_keep = ld_keep;
                if (cur_a) begin
                    n_a_pend = 1'b0;
                end else if (cur_b) begin
                    n_b_pend = 1'b0;
                end else begin
                    n_pad_pend = 1'b0;
                end
            end

            done = (n_cnt < 6'd8) && !n_a_pend && !n_b_pend
                   && !(n_pad_pend && (n_cnt != '0));

            if (done) begin
                o_sum_we         = 1'b1;
                o_sum.byte_count = n_bw;
                o_sum.overflow   = n_ovf;
                o_sum.n_res      = (n_nbytes == 4'd0) ? 4'd1 : n_nbytes;
                if (n_nbytes == 4'd0) begin
                    // A request without bytes still gives one empty result.
                    o_res_we = 1'b1;
                    o_res    = '0;
                end
                o_desc_pop = 1'b1;
                n_active   = 1'b0;
            end else begin
                n_active = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_a_pend   <= 1'b0;
            r_b_pend   <= 1'b0;
            r_pad_pend <= 1'b0;
            r_cnt      <= '0;
            r_keep     <= '0;
            r_bw       <= '0;
            r_ovf      <= 1'b0;
            r_nbytes   <= '0;
        end else begin
            r_active   <= n_active;
            r_a_pend   <= n_a_pend;
            r_b_pend   <= n_b_pend;
            r_pad_pend <= n_pad_pend;
            r_cnt      <= n_cnt;
            r_keep     <= n_keep;
            r_bw       <= n_bw;
            r_ovf      <= n_ovf;
            r_nbytes   <= n_nbytes;
        end
    end

    // Accumulator bits; only the low r_cnt bits are meaningful.
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/egbw_out.sv =====
// Result queue: byte entries plus per-request summaries, released when a request is complete.
`default_nettype none

module egbw_out #(
    parameter int DEPTH = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_res_we,
    input  wire egbw_pkg::t_res_entry        i_res,
    input  wire logic                        i_sum_we,
    input  wire egbw_pkg::t_summary          i_sum,
    output logic                             o_room,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic                             o_has_byte,
    output logic [7:0]                       o_out_byte,
    output logic [egbw_pkg::IDX_W-1:0]       o_byte_index,
    output logic [egbw_pkg::IDX_W-1:0]       o_byte_count,
    output logic                             o_overflow,
    output logic                             o_last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    egbw_pkg::t_res_entry r_res_mem [DEPTH];
    egbw_pkg::t_summary   r_sum_mem [DEPTH];
    logic [PTR_W-1:0]     r_res_wr;
    logic [PTR_W-1:0]     r_res_rd;
    logic [CNT_W-1:0]     r_res_cnt;
    logic [PTR_W-1:0]     r_sum_wr;
    logic [PTR_W-1:0]     r_sum_rd;
    logic [CNT_W-1:0]     r_sum_cnt;
    logic [2:0]           r_pos;

    egbw_pkg::t_res_entry head_res;
    egbw_pkg::t_summary   head_sum;
    logic                 do_pop;
    logic                 sum_pop;

    // Room for a whole request's results before the back end starts one.
    assign o_room = (r_res_cnt <= CNT_W'(DEPTH - egbw_pkg::MAX_RESULTS));

    // A result is visible only once its request's summary is in.
    assign head_res     = r_res_mem[r_res_rd];
    assign head_sum     = r_sum_mem[r_sum_rd];
    assign o_empty      = (r_sum_cnt == '0);
    assign o_has_byte   = head_res.has_byte;
    assign o_out_byte   = head_res.out_byte;
    assign o_byte_index = head_res.byte_index;
    assign o_byte_count = head_sum.byte_count;
    assign o_overflow   = head_sum.overflow;
    assign o_last       = (({1'b0, r_pos} + 4'd1) == head_sum.n_res);

    assign do_pop  = i_pop && !o_empty;
    assign sum_pop = do_pop && o_last;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_res_we) begin
            r_res_mem[r_res_wr] <= i_res;
        end
        if (i_sum_we) begin
            r_sum_mem[r_sum_wr] <= i_sum;
        end
    end

    // Pointers, fill counts and position within the current request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
            r_sum_wr  <= '0;
            r_sum_rd  <= '0;
            r_sum_cnt <= '0;
            r_pos     <= '0;
        end else begin
            if (i_res_we) begin
                r_res_wr <= (r_res_wr == PTR_W'(DEPTH - 1)) ? '0 : r_res_wr + 1'b1;
            end
            if (do_pop) begin
                r_res_rd <= (r_res_rd == PTR_W'(DEPTH - 1)) ? '0 : r_res_rd + 1'b1;
            end
            if (i_res_we && !do_pop) begin
                r_res_cnt <= r_res_cnt + 1'b1;
            end else if (do_pop && !i_res_we) begin
                r_res_cnt <= r_res_cnt - 1'b1;
            end

            if (i_sum_we) begin
                r_sum_wr <= (r_sum_wr == PTR_W'(DEPTH - 1)) ? '0 : r_sum_wr + 1'b1;
            end
            if (sum_pop) begin
                r_sum_rd <= (r_sum_rd == PTR_W'(DEPTH - 1)) ? '0 : r_sum_rd + 1'b1;
            end
            if (i_sum_we && !sum_pop) begin
                r_sum_cnt <= r_sum_cnt + 1'b1;
            end else if (sum_pop && !i_sum_we) begin
                r_sum_cnt <= r_sum_cnt - 1'b1;
            end

            if (sum_pop) begin
                r_pos <= '0;
            end else if (do_pop) begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/exp_golomb_bit_writer_top.sv =====
// Top level of the Exp-Golomb bit writer: front end, work queue, back end and result queue.
`default_nettype none

// MSB-first bit writer for RBSP data with Exp-Golomb codes. Requests enter through a
// queue-style port (push/full) at up to one per cycle and are classified by a one-stage
// front end into a zero prefix, a field and an optional pad step. The back end then
// works in steps: each nonempty load step, each whole byte it forms and each drop of
// the rest of a chunk on overflow is a step of its own, and a request with no work is
// a single step. The back end finishes one request before it starts the next, and its
// bit accumulator sets the sustained rate. Results leave through pop/empty; all results
// of a request appear together once the request is finished, since byte_count and
// overflow carry the values after the request. Capacity is to be written through the
// cfg channel only while the block is idle; the block itself does not enforce this.
module exp_golomb_bit_writer_top #(
    parameter int DESC_DEPTH = 4,
    parameter int RES_DEPTH  = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [30:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [31:0] i_value,
    input  wire logic [5:0]  i_bit_count,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_has_byte,
    output logic [7:0]       o_out_byte,
    output logic [30:0]      o_byte_index,
    output logic [30:0]      o_byte_count,
    output logic             o_overflow,
    output logic             o_last
);

    logic                 desc_we;
    egbw_pkg::t_desc      desc_in;
    logic                 desc_full;
    logic                 desc_pop;
    logic                 desc_valid;
    egbw_pkg::t_desc      desc_head;
    logic                 room;
    logic                 res_we;
    egbw_pkg::t_res_entry res_entry;
    logic                 sum_we;
    egbw_pkg::t_summary   sum_entry;

    // Request intake and classification.
    egbw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_bit_count (i_bit_count),
        .i_desc_full (desc_full),
        .o_desc_we   (desc_we),
        .o_desc      (desc_in)
    );

    // Work queue between the two halves.
    egbw_desc_fifo #(
        .DEPTH (DESC_DEPTH)
    ) u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (desc_we),
        .i_desc  (desc_in),
        .o_full  (desc_full),
        .i_pop   (desc_pop),
        .o_valid (desc_valid),
        .o_desc  (desc_head)
    );

    // Bit packing.
    egbw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_desc       (desc_head),
        .i_desc_valid (desc_valid),
        .o_desc_pop   (desc_pop),
        .i_room       (room),
        .o_res_we     (res_we),
        .o_res        (res_entry),
        .o_sum_we     (sum_we),
        .o_sum        (sum_entry)
    );

    // Result queue.
    egbw_out #(
        .DEPTH (RES_DEPTH)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res_we     (res_we),
        .i_res        (res_entry),
        .i_sum_we     (sum_we),
        .i_sum        (sum_entry),
        .o_room       (room),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_has_byte   (o_has_byte),
        .o_out_byte   (o_out_byte),
        .o_byte_index (o_byte_index),
        .o_byte_count (o_byte_count),
        .o_overflow   (o_overflow),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ===== bench/tb_exp_golomb_bit_writer_top.sv =====
// Self-checking testbench of the Exp-Golomb bit writer, with a byte-stream scoreboard.
`timescale 1ns / 1ps

module tb_exp_golomb_bit_writer_top;

    localparam int IDX_W     = egbw_pkg::IDX_W;
    localparam int SETTLE    = 16;
    localparam int MAX_CYC   = 400000;
    localparam int MAX_BYTES = 8;

    // Request kinds on i_req_type.
    typedef enum logic [2:0] {
        REQ_PUT     = 3'd0,
        REQ_UE      = 3'd1,
        REQ_SE      = 3'd2,
        REQ_TRAIL   = 3'd3,
        REQ_ALIGN   = 3'd4,
        REQ_START   = 3'd5,
        REQ_RESTART = 3'd6,
        REQ_UNUSED  = 3'd7
    } req_kind_e;

    typedef struct {
        req_kind_e   kind;
        logic [31:0] val;
        logic [5:0]  nbits;
    } bit_req_t;

    typedef struct {
        logic             has_byte;
        logic [7:0]       out_byte;
        logic [IDX_W-1:0] byte_index;
        logic [IDX_W-1:0] byte_count;
        logic             overflow;
        logic             last;
    } byte_res_t;

    // Scoreboard: a bit-exact model of the packer and the queue of bytes it predicts.
    class egbw_scoreboard;
        logic [IDX_W-1:0] capacity;
        logic [6:0]       pbits;
        int unsigned      pcnt;
        logic [IDX_W-1:0] written;
        logic             ovf;
        byte_res_t        fresh[$];
        byte_res_t        byte_q[$];
        int unsigned      n_errors;

        function new();
            capacity = '0;
            pbits    = '0;
            pcnt     = 0;
            written  = '0;
            ovf      = 1'b0;
            n_errors = 0;
        endfunction

        function void set_capacity(logic [IDX_W-1:0] v);
            capacity = v;
        endfunction

        function int unsigned outstanding();
            return byte_q.size();
        endfunction

        // Emit the whole bytes of one chunk; a full buffer drops the rest of the chunk.
        function void emit_chunk(logic [63:0] acc, int unsigned cnt);
            byte_res_t   r;
            logic [63:0] sh;
            bit          stop;
            stop = 1'b0;
            while (cnt >= 8 && !stop) begin
                if (written >= capacity) begin
                    ovf  = 1'b1;
                    cnt  = 0;
                    stop = 1'b1;
                end else begin
                    if (fresh.size() < MAX_BYTES) begin
                        sh           = acc >> (cnt - 8);
                        r.has_byte   = 1'b1;
                        r.out_byte   = sh[7:0];
                        r.byte_index = written;
                        fresh.push_back(r);
                    end
                    written = written + 1'b1;
                    cnt     = cnt - 8;
                end
            end
            pcnt  = cnt;
            sh    = acc & ((64'd1 << cnt) - 64'd1);
            pbits = sh[6:0];
        endfunction

        // Append a raw field; more than 32 bits in flight are split into two chunks.
        function void put_field(logic [31:0] v, int unsigned n);
            logic [63:0] acc;
            logic [31:0] tail;
            int unsigned total;
            int unsigned rest;
            if (n == 0) return;
            if (n > 32) n = 32;
            if (n < 32) v = v & ((32'd1 << n) - 32'd1);
            total = pcnt + n;
            if (total <= 32) begin
                acc = ({57'd0, pbits} << n) | {32'd0, v};
                emit_chunk(acc, total);
            end else begin
                rest = total - 32;
                acc  = ({57'd0, pbits} << (n - rest)) | {32'd0, v >> rest};
                emit_chunk(acc, 32);
                tail  = v & ((32'd1 << rest) - 32'd1);
                pbits = tail[6:0];
                pcnt  = rest;
            end
        endfunction

        // Unsigned Exp-Golomb code: zero prefix, then value plus one.
        function void put_ue(logic [31:0] v);
            logic [31:0] code;
            logic [31:0] t;
            int unsigned len;
            code = v + 32'd1;
            t    = code;
            len  = 0;
            while (t != 0) begin
                len++;
                t = t >> 1;
            end
            if (len == 0) return;
            put_field(32'd0, len - 1);
            put_field(code, len);
        endfunction

        function void pad_byte();
            if (pcnt != 0) put_field(32'd0, 8 - pcnt);
        endfunction

        // Note an accepted request and queue the results it must produce.
        function void note_request(bit_req_t q);
            logic [31:0] u;
            byte_res_t   r;
            fresh.delete();
            case (q.kind)
                REQ_PUT: put_field(q.val, q.nbits);
                REQ_UE:  put_ue(q.val);
                REQ_SE: begin
                    if (q.val == 32'd0 || q.val[31]) u = (32'd0 - q.val) << 1;
                    else u = (q.val << 1) - 32'd1;
                    put_ue(u);
                end
                REQ_TRAIL: begin
                    put_field(32'd1, 1);
                    pad_byte();
                end
                REQ_ALIGN: pad_byte();
                REQ_START: put_field(32'h0000_0001, 32);
                REQ_RESTART: begin
                    pbits   = '0;
                    pcnt    = 0;
                    written = '0;
                    ovf     = 1'b0;
                end
                default: ;
            endcase
            // A request with no byte still gives one empty result.
            if (fresh.size() == 0) begin
                r.has_byte   = 1'b0;
                r.out_byte   = '0;
                r.byte_index = '0;
                fresh.push_back(r);
            end
            foreach (fresh[i]) begin
                r            = fresh[i];
                r.byte_count = written;
                r.overflow   = ovf;
                r.last       = (i == fresh.size() - 1);
                byte_q.push_back(r);
            end
        endfunction

        function void report(string what, byte_res_t e, byte_res_t g);
            n_errors++;
            if (n_errors <= 10)
                $display("%s: exp has=%0d byte=%h idx=%0d cnt=%0d ovf=%0d last=%0d | got has=%0d byte=%h idx=%0d cnt=%0d ovf=%0d last=%0d",
                         what, e.has_byte, e.out_byte, e.byte_index, e.byte_count,
                         e.overflow, e.last, g.has_byte, g.out_byte, g.byte_index,
                         g.byte_count, g.overflow, g.last);
        endfunction

        // Compare one accepted result with the oldest predicted one.
        function void check_result(byte_res_t g);
            byte_res_t e;
            if (byte_q.size() == 0) begin
                e = '{default: '0};
                report("unexpected result", e, g);
                return;
            end
            e = byte_q.pop_front();
            if (g.has_byte !== e.has_byte || g.out_byte !== e.out_byte ||
                g.byte_index !== e.byte_index || g.byte_count !== e.byte_count ||
                g.overflow !== e.overflow || g.last !== e.last)
                report("mismatch", e, g);
        endfunction

        function void close_out();
            n_errors += byte_q.size();
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic [30:0]      i_cfg_data  = '0;
    logic             push        = 1'b0;
    logic [2:0]       i_req_type  = '0;
    logic [31:0]      i_value     = '0;
    logic [5:0]       i_bit_count = '0;
    logic             pop         = 1'b0;
    logic             o_cfg_ready;
    logic             full;
    logic             empty;
    logic             o_has_byte;
    logic [7:0]       o_out_byte;
    logic [30:0]      o_byte_index;
    logic [30:0]      o_byte_count;
    logic             o_overflow;
    logic             o_last;

    egbw_scoreboard   sb = new();
    bit_req_t         req_q[$];
    bit_req_t         driven;
    bit               calm = 1'b0;
    bit               running = 1'b0;
    int unsigned      cycles = 0;

    exp_golomb_bit_writer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_value      (i_value),
        .i_bit_count  (i_bit_count),
        .empty        (empty),
        .pop          (pop),
        .o_has_byte   (o_has_byte),
        .o_out_byte   (o_out_byte),
        .o_byte_index (o_byte_index),
        .o_byte_count (o_byte_count),
        .o_overflow   (o_overflow),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Request side: hold a refused request, otherwise push the next one or idle.
    always @(posedge i_clk) begin
        if (push && !full) begin
            sb.note_request(driven);
            void'(req_q.pop_front());
        end
        if (push && full) begin
            push <= 1'b1;
        end else if (running && req_q.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
            driven      = req_q[0];
            push        <= 1'b1;
            i_req_type  <= driven.kind;
            i_value     <= driven.val;
            i_bit_count <= driven.nbits;
        end else begin
            push <= 1'b0;
        end
    end

    // Result side: take results, with random stalls unless calm is set.
    always @(posedge i_clk) begin
        if (pop && !empty)
            sb.check_result('{o_has_byte, o_out_byte, o_byte_index, o_byte_count,
                              o_overflow, o_last});
        pop <= running && (calm || $urandom_range(99) >= 17);
    end

    task automatic send(req_kind_e kind, logic [31:0] val, logic [5:0] nbits);
        bit_req_t q;
        q.kind  = kind;
        q.val   = val;
        q.nbits = nbits;
        req_q.push_back(q);
    endtask

    // Wait until every request is taken and every predicted result has come.
    task automatic drain();
        do @(posedge i_clk);
        while (req_q.size() != 0 || push || sb.outstanding() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [30:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        sb.set_capacity(v);
        i_cfg_valid <= 1'b0;
    endtask

    // Random request, weighted toward fields and codes; restarts more often if asked.
    task automatic send_random(int unsigned n, bit many_restarts);
        int unsigned w;
        int unsigned pick;
        logic [31:0] v;
        logic [5:0]  nb;
        req_kind_e   k;
        repeat (n) begin
            pick = $urandom_range(9);
            if (pick < 4) v = $urandom_range(20);
            else if (pick < 8) v = $urandom;
            else if (pick == 8) begin
                case ($urandom_range(3))
                    0: v = 32'h0000_0000;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end else v = $urandom >> $urandom_range(31);
            nb = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(32));
            w  = $urandom_range(99);
            if (w < 35) k = REQ_PUT;
            else if (w < 55) k = REQ_UE;
            else if (w < 75) k = REQ_SE;
            else if (w < 81) k = REQ_TRAIL;
            else if (w < 88) k = REQ_ALIGN;
            else if (w < 93) k = REQ_START;
            else if (w < 96) k = REQ_UNUSED;
            else k = REQ_RESTART;
            if (many_restarts && $urandom_range(9) == 0) k = REQ_RESTART;
            send(k, v, nb);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running = 1'b1;

        // Capacity zero out of reset: every byte overflows.
        send(REQ_PUT, 32'h0000_00A5, 6'd8);
        send(REQ_PUT, 32'h0000_0005, 6'd3);
        send(REQ_RESTART, 32'h0, 6'd0);

        // Directed requests with the largest capacity.
        write_capacity(31'h7FFF_FFFF);
        send(REQ_PUT, 32'hFFFF_FFFF, 6'd0);
        send(REQ_PUT, 32'h0000_0001, 6'd1);
        send(REQ_PUT, 32'hFFFF_FFFF, 6'd32);
        send(REQ_PUT, 32'h1234_5678, 6'd63);
        send(REQ_UE, 32'h0000_0000, 6'd0);
        send(REQ_UE, 32'hFFFF_FFFF, 6'd0);
        send(REQ_UE, 32'hFFFF_FFFE, 6'd0);
        send(REQ_SE, 32'h0000_0000, 6'd0);
        send(REQ_SE, 32'h0000_0001, 6'd0);
        send(REQ_SE, 32'h7FFF_FFFF, 6'd0);
        send(REQ_SE, 32'h8000_0000, 6'd0);
        send(REQ_SE, 32'hFFFF_FFFF, 6'd0);
        send(REQ_TRAIL, 32'h0, 6'd0);
        send(REQ_ALIGN, 32'h0, 6'd0);
        send(REQ_PUT, 32'h0000_0015, 6'd5);
        send(REQ_ALIGN, 32'h0, 6'd0);
        send(REQ_START, 32'h0, 6'd0);
        send(REQ_PUT, 32'h0000_0007, 6'd3);
        send(REQ_TRAIL, 32'h0, 6'd0);
        send(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);
        send(REQ_RESTART, 32'h0, 6'd0);
        drain();

        // Random traffic: first a stretch without stalls, then with stalls.
        calm = 1'b1;
        send_random(130, 1'b0);
        drain();
        calm = 1'b0;
        send_random(140, 1'b0);

        // A small buffer so that overflow happens often.
        write_capacity(31'd12);
        send(REQ_RESTART, 32'h0, 6'd0);
        send_random(70, 1'b1);

        // A random capacity.
        write_capacity(31'($urandom_range(200)));
        send(REQ_RESTART, 32'h0, 6'd0);
        send_random(50, 1'b1);

        // Capacity zero written explicitly.
        write_capacity(31'd0);
        send_random(20, 1'b0);
        drain();

        sb.close_out();
        if (sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
